// ===== rtl/lcg_pkg.sv =====
package lcg_pkg;

    localparam int CODE_DEPTH_DEF = 16;
    localparam int USED_CODES     = 7;
    localparam int CODE_W         = 31;
    localparam int VAL_W          = 63;
    localparam int CFG_W          = 5;
    localparam int UNIT_CNT_W     = $clog2(VAL_W);

    localparam logic [CFG_W-1:0] COLLECT_RESET = 5'd10;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_CRACKED = 2'd1,
        ST_FAILED  = 2'd2
    } crack_status_t;

    typedef enum logic {
        OP_DIV    = 1'b0,
        OP_MULMOD = 1'b1
    } unit_op_t;

    // request to the shared unit: divide opa by opb, or (opa * opb) mod modv with opa < modv
    typedef struct packed {
        logic             go;
        unit_op_t         op;
        logic [VAL_W-1:0] opa;
        logic [VAL_W-1:0] opb;
        logic [VAL_W-1:0] modv;
    } unit_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quo;
        logic [VAL_W-1:0] rem;
    } unit_rsp_t;

endpackage

// ===== rtl/lcg_ram.sv =====
module lcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lcg_munit.sv =====
module lcg_munit
    import lcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    localparam logic [UNIT_CNT_W-1:0] LAST_STEP = UNIT_CNT_W'(VAL_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  add_ph_reg, add_ph_next;
    logic [UNIT_CNT_W-1:0] cnt_reg, cnt_next;
    unit_op_t              op_reg, op_next;
    logic [VAL_W-1:0]      x_reg, x_next;
    logic [VAL_W-1:0]      y_reg, y_next;
    logic [VAL_W-1:0]      m_reg, m_next;
    logic [VAL_W-1:0]      acc_reg, acc_next;

    logic [VAL_W:0]        t_w;
    logic [VAL_W+1:0]      d_w;
    logic                  ge_w;
    logic [VAL_W-1:0]      res_w;

    // one add, one compare-subtract: a division step, a doubling or an addition mod m
    always_comb
    begin
        if (add_ph_reg)
        begin
            t_w = {1'b0, acc_reg} + {1'b0, x_reg};
        end
        else
        begin
            t_w = {acc_reg, (op_reg == OP_DIV) ? y_reg[VAL_W-1] : 1'b0};
        end
        d_w   = {1'b0, t_w} - {2'b00, m_reg};
        ge_w  = ~d_w[VAL_W+1];
        res_w = ge_w ? d_w[VAL_W-1:0] : t_w[VAL_W-1:0];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        add_ph_next = add_ph_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;

        if (busy_reg)
        begin
            acc_next = res_w;
            if (op_reg == OP_DIV)
            begin
                y_next   = {y_reg[VAL_W-2:0], ge_w};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else if (!add_ph_reg && y_reg[VAL_W-1])
            begin
                // hold the bit for the addition phase
                add_ph_next = 1'b1;
            end
            else
            begin
                add_ph_next = 1'b0;
                y_next      = {y_reg[VAL_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
        else if (req.go)
        begin
            busy_next   = 1'b1;
            add_ph_next = 1'b0;
            cnt_next    = '0;
            op_next     = req.op;
            acc_next    = '0;
            if (req.op == OP_DIV)
            begin
                x_next = '0;
                y_next = req.opa;
                m_next = req.opb;
            end
            else
            begin
                x_next = req.opa;
                y_next = req.opb;
                m_next = req.modv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            add_ph_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            add_ph_reg <= add_ph_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = y_reg;
    assign rsp.rem  = acc_reg;

endmodule

// ===== rtl/lcg_parameter_cracker.sv =====
// Recovers modulus, multiplier and increment of a linear congruential generator from the
// observed codes and returns, for every code taken, the crack status, the parameters, the
// prediction of the next code and the number of distinct codes stored. One item at a time:
// code_stall is high from acceptance until the result is loaded into the output register.
// An ordinary item scans the N codes stored, one RAM read and compare per entry, then hands
// a 63-bit modular multiply for the prediction to the shared unit through the registered
// request and done signals; a zero code skips the scan. A stalled output register holds
// the item in S_FIN until the previous result is taken. The item that completes the
// collection also runs the one-time crack: every remainder step of the gcd and of the
// inverse is a division, each inverse step also a modular multiply, all on one shared
// add/compare unit, so that item's length depends on how many Euclid steps the codes
// need. No clearing pass after reset.
module lcg_parameter_cracker
    import lcg_pkg::*;
#(
    parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  collect_count,
    input  logic              code_valid,
    output logic              code_stall,
    input  logic [CODE_W-1:0] code,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [1:0]        crack_status,
    output logic [VAL_W-1:0]  modulus,
    output logic [VAL_W-1:0]  multiplier,
    output logic [VAL_W-1:0]  increment,
    output logic [VAL_W-1:0]  predicted_next,
    output logic [4:0]        stored_count
);

    localparam int IDX_W = $clog2(CODE_DEPTH);
    localparam int CNT_W = $clog2(CODE_DEPTH + 1);

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_SCAN      = 23'h000002,
        S_SCAN_CMP  = 23'h000004,
        S_APPEND    = 23'h000008,
        S_CHECK     = 23'h000010,
        S_LOAD      = 23'h000020,
        S_LOAD_WR   = 23'h000040,
        S_PROD_A    = 23'h000080,
        S_PROD_B    = 23'h000100,
        S_DIFF      = 23'h000200,
        S_GCD_CHK   = 23'h000400,
        S_GCD_WAIT  = 23'h000800,
        S_MCHK      = 23'h001000,
        S_T0_WAIT   = 23'h002000,
        S_INV_CHK   = 23'h004000,
        S_INV_DIV   = 23'h008000,
        S_INV_MUL   = 23'h010000,
        S_T1_WAIT   = 23'h020000,
        S_A_WAIT    = 23'h040000,
        S_P_WAIT    = 23'h080000,
        S_C1_WAIT   = 23'h100000,
        S_PRED_WAIT = 23'h200000,
        S_FIN       = 23'h400000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    crack_status_t        status_reg, status_next;
    logic [VAL_W-1:0]     mod_reg, mod_next;
    logic [VAL_W-1:0]     mul_reg, mul_next;
    logic [VAL_W-1:0]     inc_reg, inc_next;
    logic [CFG_W-1:0]     collect_reg, collect_next;
    logic                 res_valid_reg, res_valid_next;
    unit_req_t            req_reg, req_next;

    logic [CODE_W-1:0]    code_reg, code_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 seen_reg, seen_next;
    logic [CODE_W-1:0]    c_reg [USED_CODES];
    logic [CODE_W-1:0]    c_next [USED_CODES];
    logic [1:0]           k_reg, k_next;
    logic signed [63:0]   prod_reg, prod_next;
    logic signed [63:0]   sq_reg, sq_next;
    logic [VAL_W-1:0]     g_reg, g_next;
    logic [VAL_W-1:0]     gx_reg, gx_next;
    logic [VAL_W-1:0]     gy_reg, gy_next;
    logic [VAL_W-1:0]     ca_reg, ca_next;
    logic [VAL_W-1:0]     cb_reg, cb_next;
    logic [VAL_W-1:0]     tmp_reg, tmp_next;
    logic [VAL_W-1:0]     a_reg, a_next;
    logic [VAL_W-1:0]     p_reg, p_next;
    logic [VAL_W-1:0]     pred_reg, pred_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [VAL_W-1:0]     res_mod_reg, res_mod_next;
    logic [VAL_W-1:0]     res_mul_reg, res_mul_next;
    logic [VAL_W-1:0]     res_inc_reg, res_inc_next;
    logic [VAL_W-1:0]     res_pred_reg, res_pred_next;
    logic [4:0]           res_count_reg, res_count_next;

    unit_rsp_t            rsp;
    logic                 ram_we;
    logic [CODE_W-1:0]    ram_rdata;

    logic signed [31:0]   t_w [USED_CODES-1];
    logic signed [31:0]   t_k0, t_k1, t_k2;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   mult_w;
    logic signed [63:0]   diff_w;
    logic [VAL_W-1:0]     mag_w;
    logic [31:0]          t0_abs, t1_abs;
    logic [CFG_W-1:0]     need_w;
    logic                 enough_w;
    logic                 in_accept;
    logic                 out_take;

    function automatic logic [VAL_W-1:0] mod_sub(
        input logic [VAL_W-1:0] x,
        input logic [VAL_W-1:0] y,
        input logic [VAL_W-1:0] m
    );
        logic [VAL_W:0] lo;
        logic [VAL_W:0] hi;
        lo = {1'b0, x} - {1'b0, y};
        hi = {1'b0, x} + ({1'b0, m} - {1'b0, y});
        return lo[VAL_W] ? hi[VAL_W-1:0] : lo[VAL_W-1:0];
    endfunction

    lcg_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CODE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (code_reg),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lcg_munit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    always_comb
    begin
        for (int i = 0; i < USED_CODES - 1; i++)
        begin
            t_w[i] = $signed({1'b0, c_reg[i+1]}) - $signed({1'b0, c_reg[i]});
        end
    end

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                t_k0 = t_w[0];
                t_k1 = t_w[1];
                t_k2 = t_w[2];
            end
            2'd1:
            begin
                t_k0 = t_w[1];
                t_k1 = t_w[2];
                t_k2 = t_w[3];
            end
            2'd2:
            begin
                t_k0 = t_w[2];
                t_k1 = t_w[3];
                t_k2 = t_w[4];
            end
            default:
            begin
                t_k0 = t_w[3];
                t_k1 = t_w[4];
                t_k2 = t_w[5];
            end
        endcase
    end

    assign mul_a  = (state_reg == S_PROD_B) ? t_k1 : t_k2;
    assign mul_b  = (state_reg == S_PROD_B) ? t_k1 : t_k0;
    assign mult_w = mul_a * mul_b;
    assign diff_w = prod_reg - sq_reg;
    assign mag_w  = diff_w[63] ? 63'(-diff_w) : diff_w[VAL_W-1:0];
    assign t0_abs = t_w[0][31] ? 32'(-t_w[0]) : 32'(t_w[0]);
    assign t1_abs = t_w[1][31] ? 32'(-t_w[1]) : 32'(t_w[1]);

    assign need_w    = (collect_reg < CFG_W'(USED_CODES)) ? CFG_W'(USED_CODES) : collect_reg;
    assign enough_w  = (32'(count_reg) >= 32'(need_w));
    assign in_accept = code_valid && !code_stall;
    assign out_take  = res_valid_reg && !result_stall;
    assign ram_we    = (state_reg == S_APPEND) && !seen_reg &&
                       (count_reg < CNT_W'(CODE_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        mod_next        = mod_reg;
        mul_next        = mul_reg;
        inc_next        = inc_reg;
        collect_next    = cfg_valid ? collect_count : collect_reg;
        res_valid_next  = out_take ? 1'b0 : res_valid_reg;
        req_next        = req_reg;
        req_next.go     = 1'b0;
        code_next       = code_reg;
        idx_next        = idx_reg;
        seen_next       = seen_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        sq_next         = sq_reg;
        g_next          = g_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        tmp_next        = tmp_reg;
        a_next          = a_reg;
        p_next          = p_reg;
        pred_next       = pred_reg;
        res_status_next = res_status_reg;
        res_mod_next    = res_mod_reg;
        res_mul_next    = res_mul_reg;
        res_inc_next    = res_inc_reg;
        res_pred_next   = res_pred_reg;
        res_count_next  = res_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    code_next  = code;
                    idx_next   = '0;
                    seen_next  = 1'b0;
                    state_next = (code == '0) ? S_CHECK : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read of entry idx is issued here, data comes back next cycle
                state_next = (idx_reg == count_reg) ? S_APPEND : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (ram_rdata == code_reg)
                begin
                    seen_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_APPEND:
            begin
                if (ram_we)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (enough_w && status_reg == ST_NONE)
                begin
                    idx_next   = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = mul_reg;
                    req_next.opb  = VAL_W'(code_reg);
                    req_next.modv = mod_reg;
                    state_next    = S_PRED_WAIT;
                end
            end
            S_LOAD:
            begin
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                c_next[idx_reg[2:0]] = ram_rdata;
                if (idx_reg == CNT_W'(USED_CODES - 1))
                begin
                    k_next     = '0;
                    state_next = S_PROD_A;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_PROD_A:
            begin
                prod_next  = mult_w;
                state_next = S_PROD_B;
            end
            S_PROD_B:
            begin
                sq_next    = mult_w;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (k_reg == 2'd0)
                begin
                    g_next     = mag_w;
                    k_next     = k_reg + 1'b1;
                    state_next = S_PROD_A;
                end
                else
                begin
                    gx_next    = mag_w;
                    gy_next    = g_reg;
                    state_next = S_GCD_CHK;
                end
            end
            S_GCD_CHK:
            begin
                if (gy_reg == '0)
                begin
                    g_next = gx_reg;
                    if (k_reg == 2'd3)
                    begin
                        state_next = S_MCHK;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_PROD_A;
                    end
                end
                else
                begin
                    req_next.go  = 1'b1;
                    req_next.op  = OP_DIV;
                    req_next.opa = gx_reg;
                    req_next.opb = gy_reg;
                    state_next   = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (rsp.done)
                begin
                    gx_next    = gy_reg;
                    gy_next    = rsp.rem;
                    state_next = S_GCD_CHK;
                end
            end
            S_MCHK:
            begin
                if (g_reg <= VAL_W'(1))
                begin
                    status_next   = ST_FAILED;
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = mul_reg;
                    req_next.opb  = VAL_W'(code_reg);
                    req_next.modv = mod_reg;
                    state_next    = S_PRED_WAIT;
                end
                else
                begin
                    req_next.go  = 1'b1;
                    req_next.op  = OP_DIV;
                    req_next.opa = VAL_W'(t0_abs);
                    req_next.opb = g_reg;
                    state_next   = S_T0_WAIT;
                end
            end
            S_T0_WAIT:
            begin
                if (rsp.done)
                begin
                    gx_next = g_reg;
                    if (t_w[0][31] && rsp.rem != '0)
                    begin
                        gy_next = g_reg - rsp.rem;
                    end
                    else
                    begin
                        gy_next = rsp.rem;
                    end
                    ca_next    = '0;
                    cb_next    = VAL_W'(1);
                    state_next = S_INV_CHK;
                end
            end
            S_INV_CHK:
            begin
                if (gy_reg == '0)
                begin
                    req_next.go = 1'b1;
                    if (gx_reg != VAL_W'(1))
                    begin
                        // no inverse: fail and predict with the reset parameters
                        status_next   = ST_FAILED;
                        req_next.op   = OP_MULMOD;
                        req_next.opa  = mul_reg;
                        req_next.opb  = VAL_W'(code_reg);
                        req_next.modv = mod_reg;
                        state_next    = S_PRED_WAIT;
                    end
                    else
                    begin
                        req_next.op  = OP_DIV;
                        req_next.opa = VAL_W'(t1_abs);
                        req_next.opb = g_reg;
                        state_next   = S_T1_WAIT;
                    end
                end
                else
                begin
                    req_next.go  = 1'b1;
                    req_next.op  = OP_DIV;
                    req_next.opa = gx_reg;
                    req_next.opb = gy_reg;
                    state_next   = S_INV_DIV;
                end
            end
            S_INV_DIV:
            begin
                if (rsp.done)
                begin
                    tmp_next      = rsp.rem;
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = cb_reg;
                    req_next.opb  = rsp.quo;
                    req_next.modv = g_reg;
                    state_next    = S_INV_MUL;
                end
            end
            S_INV_MUL:
            begin
                if (rsp.done)
                begin
                    gx_next    = gy_reg;
                    gy_next    = tmp_reg;
                    ca_next    = cb_reg;
                    cb_next    = mod_sub(ca_reg, rsp.rem, g_reg);
                    state_next = S_INV_CHK;
                end
            end
            S_T1_WAIT:
            begin
                if (rsp.done)
                begin
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = ca_reg;
                    req_next.modv = g_reg;
                    if (t_w[1][31] && rsp.rem != '0)
                    begin
                        req_next.opb = g_reg - rsp.rem;
                    end
                    else
                    begin
                        req_next.opb = rsp.rem;
                    end
                    state_next = S_A_WAIT;
                end
            end
            S_A_WAIT:
            begin
                if (rsp.done)
                begin
                    a_next        = rsp.rem;
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = rsp.rem;
                    req_next.opb  = VAL_W'(c_reg[0]);
                    req_next.modv = g_reg;
                    state_next    = S_P_WAIT;
                end
            end
            S_P_WAIT:
            begin
                if (rsp.done)
                begin
                    p_next       = rsp.rem;
                    req_next.go  = 1'b1;
                    req_next.op  = OP_DIV;
                    req_next.opa = VAL_W'(c_reg[1]);
                    req_next.opb = g_reg;
                    state_next   = S_C1_WAIT;
                end
            end
            S_C1_WAIT:
            begin
                if (rsp.done)
                begin
                    mod_next      = g_reg;
                    mul_next      = a_reg;
                    inc_next      = mod_sub(rsp.rem, p_reg, g_reg);
                    status_next   = ST_CRACKED;
                    req_next.go   = 1'b1;
                    req_next.op   = OP_MULMOD;
                    req_next.opa  = a_reg;
                    req_next.opb  = VAL_W'(code_reg);
                    req_next.modv = g_reg;
                    state_next    = S_PRED_WAIT;
                end
            end
            S_PRED_WAIT:
            begin
                if (rsp.done)
                begin
                    pred_next  = mod_sub(rsp.rem, mod_reg - inc_reg, mod_reg);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_mod_next    = mod_reg;
                    res_mul_next    = mul_reg;
                    res_inc_next    = inc_reg;
                    res_pred_next   = pred_reg;
                    res_count_next  = 5'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_NONE;
            mod_reg       <= VAL_W'(1);
            mul_reg       <= '0;
            inc_reg       <= '0;
            collect_reg   <= COLLECT_RESET;
            res_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            mod_reg       <= mod_next;
            mul_reg       <= mul_next;
            inc_reg       <= inc_next;
            collect_reg   <= collect_next;
            res_valid_reg <= res_valid_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        idx_reg        <= idx_next;
        seen_reg       <= seen_next;
        c_reg          <= c_next;
        k_reg          <= k_next;
        prod_reg       <= prod_next;
        sq_reg         <= sq_next;
        g_reg          <= g_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        ca_reg         <= ca_next;
        cb_reg         <= cb_next;
        tmp_reg        <= tmp_next;
        a_reg          <= a_next;
        p_reg          <= p_next;
        pred_reg       <= pred_next;
        res_status_reg <= res_status_next;
        res_mod_reg    <= res_mod_next;
        res_mul_reg    <= res_mul_next;
        res_inc_reg    <= res_inc_next;
        res_pred_reg   <= res_pred_next;
        res_count_reg  <= res_count_next;
    end

    assign cfg_ready      = 1'b1;
    assign code_stall     = (state_reg != S_IDLE);
    assign result_valid   = res_valid_reg;
    assign crack_status   = res_status_reg;
    assign modulus        = res_mod_reg;
    assign multiplier     = res_mul_reg;
    assign increment      = res_inc_reg;
    assign predicted_next = res_pred_reg;
    assign stored_count   = res_count_reg;

endmodule
